/* design/csrb_pkg.sv */
// Package for the sorted-edge CSR builder: request, status and state codes,
// configuration indexes, fixed field widths and the result record.
// No dependencies.
`timescale 1ns / 1ps

package csrb_pkg;

  localparam int REQ_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 13;
  localparam int NVCFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [NVCFG_W-1:0] NUM_VERTICES_RST = NVCFG_W'(1024);

  typedef enum logic [REQ_W-1:0] {
    REQ_BEGIN    = 3'd0,
    REQ_EDGE     = 3'd1,
    REQ_FINISH   = 3'd2,
    REQ_READ_ROW = 3'd3,
    REQ_READ_COL = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 3'd0,
    STAT_RANGE  = 3'd1,
    STAT_ORDER  = 3'd2,
    STAT_FULL   = 3'd3,
    STAT_BADIDX = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_VERTEX  = 1'b0,
    CFG_NUM_VERTICES = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_READ
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    status_t           status;
  } res_t;

endpackage

/* design/sorted_edge_to_csr_builder.sv */
// Sorted-edge CSR builder top level: sequencer plus row-pointer and column RAMs.
// Begin, rejected items and edges that open no new rows complete with busy low; an edge
// that opens rows first fills the row pointers up to its source row, and a finish fills
// them up to the vertex count. A new transfer is taken at the result's edge.
// Reset clears control and configuration; the RAMs keep their contents.
// Results are strobed on out_valid for one cycle and cannot be stalled.
`timescale 1ns / 1ps

module sorted_edge_to_csr_builder
  import csrb_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [DATA_W-1:0]    in_source_vertex,
  input  logic [DATA_W-1:0]    in_target_vertex,
  input  logic [IDX_W-1:0]     in_read_index,
  output logic                 out_valid,
  output logic [DATA_W-1:0]    out_read_value,
  output logic [STATUS_W-1:0]  out_status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  localparam int RP_DEPTH = MAX_VERTICES + 1;
  localparam int RP_AW    = $clog2(RP_DEPTH);
  localparam int CS_AW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W    = $clog2(MAX_EDGES + 1);

  logic              rp_we, rp_re;
  logic [RP_AW-1:0]  rp_waddr, rp_raddr;
  logic [CNT_W-1:0]  rp_wdata, rp_rdata;
  logic              cs_we, cs_re;
  logic [CS_AW-1:0]  cs_waddr, cs_raddr;
  logic [DATA_W-1:0] cs_wdata, cs_rdata;
  res_t              res;

  csrb_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .RP_AW        (RP_AW),
    .CS_AW        (CS_AW),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_source_vertex (in_source_vertex),
    .in_target_vertex (in_target_vertex),
    .in_read_index    (in_read_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .rp_we            (rp_we),
    .rp_waddr         (rp_waddr),
    .rp_wdata         (rp_wdata),
    .rp_re            (rp_re),
    .rp_raddr         (rp_raddr),
    .rp_rdata         (rp_rdata),
    .cs_we            (cs_we),
    .cs_waddr         (cs_waddr),
    .cs_wdata         (cs_wdata),
    .cs_re            (cs_re),
    .cs_raddr         (cs_raddr),
    .cs_rdata         (cs_rdata),
    .res              (res)
  );

  csrb_ram #(
    .DEPTH (RP_DEPTH),
    .WIDTH (CNT_W),
    .AW    (RP_AW)
  ) u_row_ram (
    .clk   (clk),
    .we    (rp_we),
    .waddr (rp_waddr),
    .wdata (rp_wdata),
    .re    (rp_re),
    .raddr (rp_raddr),
    .rdata (rp_rdata)
  );

  csrb_ram #(
    .DEPTH (MAX_EDGES),
    .WIDTH (DATA_W),
    .AW    (CS_AW)
  ) u_col_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .re    (cs_re),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  assign out_valid      = res.valid;
  assign out_read_value = res.value;
  assign out_status     = res.status;

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a transfer or work in progress");

  a_begin_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_BEGIN)) |=> (out_valid && !busy))
    else $error("begin did not complete in one cycle");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_read_value == '0))
    else $error("failed item returned a nonzero value");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result right after reset");

endmodule

/* design/csrb_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module csrb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/csrb_ctrl.sv */
// Sequencer of the CSR builder: configuration registers, edge count, row
// fill walk and read handling over the row-pointer and column RAMs.
// Depends on csrb_pkg.
`timescale 1ns / 1ps

module csrb_ctrl
  import csrb_pkg::*;
#(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int RP_AW        = $clog2(MAX_VERTICES + 1),
  parameter int CS_AW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  parameter int CNT_W        = $clog2(MAX_EDGES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [DATA_W-1:0]    in_source_vertex,
  input  logic [DATA_W-1:0]    in_target_vertex,
  input  logic [IDX_W-1:0]     in_read_index,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  output logic                 rp_we,
  output logic [RP_AW-1:0]     rp_waddr,
  output logic [CNT_W-1:0]     rp_wdata,
  output logic                 rp_re,
  output logic [RP_AW-1:0]     rp_raddr,
  input  logic [CNT_W-1:0]     rp_rdata,
  output logic                 cs_we,
  output logic [CS_AW-1:0]     cs_waddr,
  output logic [DATA_W-1:0]    cs_wdata,
  output logic                 cs_re,
  output logic [CS_AW-1:0]     cs_raddr,
  input  logic [DATA_W-1:0]    cs_rdata,
  output res_t                 res
);

  state_t               state_r, state_nxt;
  logic [DATA_W-1:0]    base_vertex_r;
  logic [NVCFG_W-1:0]   num_vertices_r;
  logic [CNT_W-1:0]     edge_count_r, edge_count_nxt;
  logic [RP_AW-1:0]     next_row_r, next_row_nxt;
  logic [RP_AW-1:0]     fill_idx_r, fill_idx_nxt;
  logic [RP_AW-1:0]     fill_last_r, fill_last_nxt;
  logic                 fill_edge_r, fill_edge_nxt;
  logic [DATA_W-1:0]    target_r, target_nxt;
  logic                 rd_col_r, rd_col_nxt;
  res_t                 res_r, res_nxt;

  logic [RP_AW-1:0]     nv;
  logic [DATA_W-1:0]    nv32;
  logic [DATA_W-1:0]    next32;
  logic [DATA_W-1:0]    cnt32;
  logic [DATA_W-1:0]    idx32;
  logic [DATA_W-1:0]    local32;
  logic [DATA_W-1:0]    local_p1;

  always_comb begin
    if (DATA_W'(num_vertices_r) > DATA_W'(MAX_VERTICES)) begin
      nv = RP_AW'(MAX_VERTICES);
    end else begin
      nv = RP_AW'(num_vertices_r);
    end
  end

  assign nv32     = DATA_W'(nv);
  assign next32   = DATA_W'(next_row_r);
  assign cnt32    = DATA_W'(edge_count_r);
  assign idx32    = DATA_W'(in_read_index);
  assign local32  = in_source_vertex - base_vertex_r;
  assign local_p1 = local32 + DATA_W'(1);
  assign busy     = (state_r != S_IDLE);
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_vertex_r  <= '0;
      num_vertices_r <= NUM_VERTICES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_VERTEX:  base_vertex_r  <= cfg_wdata;
        CFG_NUM_VERTICES: num_vertices_r <= cfg_wdata[NVCFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edge_count_r <= '0;
      next_row_r   <= '0;
      res_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      edge_count_r <= edge_count_nxt;
      next_row_r   <= next_row_nxt;
      res_r        <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_idx_r   <= fill_idx_nxt;
    fill_last_r  <= fill_last_nxt;
    fill_edge_r  <= fill_edge_nxt;
    target_r     <= target_nxt;
    rd_col_r     <= rd_col_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    edge_count_nxt = edge_count_r;
    next_row_nxt   = next_row_r;
    fill_idx_nxt   = fill_idx_r;
    fill_last_nxt  = fill_last_r;
    fill_edge_nxt  = fill_edge_r;
    target_nxt     = target_r;
    rd_col_nxt     = rd_col_r;
    res_nxt.valid  = 1'b0;
    res_nxt.value  = '0;
    res_nxt.status = STAT_OK;
    rp_we          = 1'b0;
    rp_waddr       = fill_idx_r;
    rp_wdata       = edge_count_r;
    rp_re          = 1'b0;
    rp_raddr       = RP_AW'(idx32);
    cs_we          = 1'b0;
    cs_waddr       = CS_AW'(edge_count_r);
    cs_wdata       = in_target_vertex;
    cs_re          = 1'b0;
    cs_raddr       = CS_AW'(idx32);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_req_type)
            REQ_BEGIN: begin
              edge_count_nxt = '0;
              next_row_nxt   = '0;
              res_nxt.valid  = 1'b1;
            end
            REQ_EDGE: begin
              res_nxt.valid = 1'b1;
              if ((in_source_vertex < base_vertex_r) || (local32 >= nv32)) begin
                res_nxt.status = STAT_RANGE;
              end else if (local_p1 < next32) begin
                res_nxt.status = STAT_ORDER;
              end else if (cnt32 >= DATA_W'(MAX_EDGES)) begin
                res_nxt.status = STAT_FULL;
              end else if (local_p1 > next32) begin
                res_nxt.valid = 1'b0;
                state_nxt     = S_FILL;
                fill_idx_nxt  = next_row_r;
                fill_last_nxt = RP_AW'(local32);
                fill_edge_nxt = 1'b1;
                target_nxt    = in_target_vertex;
              end else begin
                cs_we          = 1'b1;
                edge_count_nxt = edge_count_r + CNT_W'(1);
              end
            end
            REQ_FINISH: begin
              if (next32 <= nv32) begin
                state_nxt     = S_FILL;
                fill_idx_nxt  = next_row_r;
                fill_last_nxt = nv;
                fill_edge_nxt = 1'b0;
              end else begin
                res_nxt.valid = 1'b1;
              end
            end
            REQ_READ_ROW: begin
              if (idx32 <= nv32) begin
                rp_re      = 1'b1;
                rd_col_nxt = 1'b0;
                state_nxt  = S_READ;
              end else begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = STAT_BADIDX;
              end
            end
            REQ_READ_COL: begin
              if ((idx32 < cnt32) && (idx32 < DATA_W'(MAX_EDGES))) begin
                cs_re      = 1'b1;
                rd_col_nxt = 1'b1;
                state_nxt  = S_READ;
              end else begin
                res_nxt.valid  = 1'b1;
                res_nxt.status = STAT_BADIDX;
              end
            end
            default: begin
              res_nxt.valid = 1'b1;
            end
          endcase
        end
      end
      S_FILL: begin
        rp_we = 1'b1;
        if (fill_idx_r == fill_last_r) begin
          res_nxt.valid = 1'b1;
          state_nxt     = S_IDLE;
          if (fill_edge_r) begin
            cs_we          = 1'b1;
            cs_wdata       = target_r;
            edge_count_nxt = edge_count_r + CNT_W'(1);
            next_row_nxt   = fill_last_r + RP_AW'(1);
          end
        end else begin
          fill_idx_nxt = fill_idx_r + RP_AW'(1);
        end
      end
      S_READ: begin
        res_nxt.valid = 1'b1;
        res_nxt.value = rd_col_r ? cs_rdata : DATA_W'(rp_rdata);
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
